### sv/pbb_pkg.sv
// Shared types and command codes for the path builder with bounding box.
package pbb_pkg;

  typedef enum logic [3:0] {
    ACT_NEW    = 4'd0,
    ACT_MOVE   = 4'd1,
    ACT_RMOVE  = 4'd2,
    ACT_LINE   = 4'd3,
    ACT_RLINE  = 4'd4,
    ACT_CURVE  = 4'd5,
    ACT_RCURVE = 4'd6,
    ACT_CLOSE  = 4'd7,
    ACT_BBOX   = 4'd8,
    ACT_READ   = 4'd9
  } action_e;

  localparam logic [2:0] KIND_CLOSE = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_POINT = 2'd1;
  localparam logic [1:0] ST_LIMIT    = 2'd2;
  localparam logic [1:0] ST_BAD_IDX  = 2'd3;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] pt1_x;
    logic signed [31:0] pt1_y;
    logic signed [31:0] pt2_x;
    logic signed [31:0] pt2_y;
    logic signed [31:0] pt3_x;
    logic signed [31:0] pt3_y;
    logic               skip_trailing_move;
    logic [10:0]        node_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] current_x;
    logic signed [31:0] current_y;
    logic [11:0]        node_total;
    logic signed [31:0] box_low_x;
    logic signed [31:0] box_low_y;
    logic signed [31:0] box_high_x;
    logic signed [31:0] box_high_y;
    logic [2:0]         read_kind;
    logic signed [31:0] read_x;
    logic signed [31:0] read_y;
  } res_t;

  // Memory port request from the sequencer.
  typedef struct packed {
    logic        wr;
    logic        rd;
    logic [15:0] addr;
  } mreq_t;

endpackage

### sv/path_builder_with_bbox_core.sv
// Top level: path command sequencer around the node memory and box tracker.
//
//  channel | direction | payload          | handshake
//  cmd     | in        | pbb_pkg::cmd_t   | cmd_valid_i / cmd_stall_o
//  res     | out       | pbb_pkg::res_t   | res_valid_o / res_stall_i
//
// A command is taken only in idle and the next is stalled until it is done. A plain
// command executes and then outputs; a curve makes three node writes through the one
// memory port, and a close or a read adds a memory read, its wait, then the write or
// capture. The result is built in a work register and moves to the output
// register once that is free or being emptied, so a stalled result holds the next
// command only in its output state. Reset leaves an empty path; the node memory
// needs no clearing since only written entries are ever read.
module path_builder_with_bbox_core #(
  parameter int NODE_DEPTH  = 2048,
  parameter int COORD_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_stall_o,
  input  pbb_pkg::cmd_t  cmd_i,
  output logic           res_valid_o,
  input  logic           res_stall_i,
  output pbb_pkg::res_t  res_o
);

  localparam int Cw = COORD_WIDTH;
  localparam int Ew = ((Cw > 32) ? Cw : 32) + 2;
  localparam int Aw = $clog2(NODE_DEPTH);
  localparam int Nw = $clog2(NODE_DEPTH + 1);
  localparam logic signed [Cw:0] Hi = (Cw+1)'((65'(1) << (Cw - 1)) - 65'(1));
  localparam logic signed [Cw:0] Lo = -Hi - (Cw+1)'(1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_WAIT = 5'b00100,
    S_RESP = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  pbb_pkg::cmd_t cmd_q;
  logic [1:0] step_q;
  logic [Nw-1:0] cnt_q;
  logic signed [Cw-1:0] hx_q, hy_q, sx_q, sy_q, bx_q, by_q;
  logic res_valid_q;
  pbb_pkg::res_t res_q, res_d, work_q, work_d;

  // Saturate a sign-extended 32-bit value or sum to the coordinate range.
  function automatic logic signed [Cw-1:0] sat(input logic signed [Ew-1:0] v);
    if (v > Ew'(Hi)) return Hi[Cw-1:0];
    if (v < Ew'(Lo)) return Lo[Cw-1:0];
    return v[Cw-1:0];
  endfunction

  function automatic logic signed [Ew-1:0] ext32(input logic signed [31:0] v);
    return Ew'(v);
  endfunction

  logic signed [31:0] opx, opy;
  logic signed [Cw-1:0] nx, ny;
  logic rel;
  logic [3:0] act;
  logic have;
  logic [Nw-1:0] room;

  assign act  = cmd_q.action;
  assign have = cnt_q != '0;
  assign room = Nw'(NODE_DEPTH) - cnt_q;
  assign rel  = act == pbb_pkg::ACT_RMOVE || act == pbb_pkg::ACT_RLINE ||
                act == pbb_pkg::ACT_RCURVE;

  always_comb begin
    case (step_q)
      2'd1:    begin opx = cmd_q.pt2_x; opy = cmd_q.pt2_y; end
      2'd2:    begin opx = cmd_q.pt3_x; opy = cmd_q.pt3_y; end
      default: begin opx = cmd_q.pt1_x; opy = cmd_q.pt1_y; end
    endcase
    if (rel) begin
      nx = sat(ext32(opx) + Ew'(bx_q));
      ny = sat(ext32(opy) + Ew'(by_q));
    end else begin
      nx = sat(ext32(opx));
      ny = sat(ext32(opy));
    end
  end

  // Memory and box control.
  logic m_wr, m_rd, b_pt, b_clr, b_drawn;
  logic [Aw-1:0] m_addr;
  logic [2:0] m_kind, r_kind;
  logic [Cw-1:0] m_x, m_y, r_x, r_y;
  logic signed [Cw-1:0] box [4];
  logic [1:0] st;
  logic is_pt, is_curve;

  assign is_pt    = act >= pbb_pkg::ACT_MOVE && act <= pbb_pkg::ACT_RLINE;
  assign is_curve = act == pbb_pkg::ACT_CURVE || act == pbb_pkg::ACT_RCURVE;

  always_comb begin
    st = pbb_pkg::ST_OK;
    if ((is_pt && act != pbb_pkg::ACT_MOVE) || is_curve || act == pbb_pkg::ACT_BBOX) begin
      if (!have) st = pbb_pkg::ST_NO_POINT;
      else if (is_pt && room == '0) st = pbb_pkg::ST_LIMIT;
      // The room of a curve is judged once, before its first node is written.
      else if (is_curve && step_q == 2'd0 && room < Nw'(3)) st = pbb_pkg::ST_LIMIT;
    end else if (act == pbb_pkg::ACT_MOVE && room == '0) begin
      st = pbb_pkg::ST_LIMIT;
    end else if (act == pbb_pkg::ACT_CLOSE && have && room == '0) begin
      st = pbb_pkg::ST_LIMIT;
    end else if (act == pbb_pkg::ACT_READ &&
                 (32'(cmd_q.node_index) >= 32'(cnt_q) ||
                  32'(cmd_q.node_index) >= 32'(NODE_DEPTH))) begin
      st = pbb_pkg::ST_BAD_IDX;
    end
  end

  logic ok_write;
  assign ok_write = state_q == S_EXEC && st == pbb_pkg::ST_OK && (is_pt || is_curve);

  always_comb begin
    m_wr = 1'b0; m_rd = 1'b0;
    m_addr = cnt_q[Aw-1:0];
    m_kind = act[2:0]; m_x = nx; m_y = ny;
    b_pt = 1'b0; b_clr = 1'b0;
    b_drawn = act >= pbb_pkg::ACT_LINE;
    if (state_q == S_EXEC) begin
      if (ok_write) begin
        m_wr = 1'b1; b_pt = 1'b1;
      end else if (act == pbb_pkg::ACT_NEW) begin
        b_clr = 1'b1;
      end else if (act == pbb_pkg::ACT_CLOSE && have && st == pbb_pkg::ST_OK) begin
        m_rd = 1'b1; m_addr = Aw'(cnt_q - Nw'(1));
      end else if (act == pbb_pkg::ACT_READ && st == pbb_pkg::ST_OK) begin
        m_rd = 1'b1; m_addr = Aw'(cmd_q.node_index);
      end
    end else if (state_q == S_RESP && act == pbb_pkg::ACT_CLOSE &&
                 r_kind != pbb_pkg::KIND_CLOSE) begin
      m_wr = 1'b1; m_kind = pbb_pkg::KIND_CLOSE; m_x = sx_q; m_y = sy_q;
    end
  end

  pbb_node_mem #(.Depth(NODE_DEPTH), .Cw(Cw), .Aw(Aw)) u_mem (
    .clk_i, .wr_i(m_wr), .rd_i(m_rd), .addr_i(m_addr),
    .wkind_i(m_kind), .wx_i(m_x), .wy_i(m_y),
    .rkind_o(r_kind), .rx_o(r_x), .ry_o(r_y)
  );

  pbb_box #(.Cw(Cw)) u_box (
    .clk_i, .rst_ni, .clear_i(b_clr), .pt_i(b_pt), .drawn_i(b_drawn),
    .x_i(nx), .y_i(ny), .sel_drawn_i(cmd_q.skip_trailing_move), .box_o(box)
  );

  logic take;
  assign cmd_stall_o = state_q != S_IDLE;
  assign take = cmd_valid_i && !cmd_stall_o;

  logic last_step;
  assign last_step = !is_curve || step_q == 2'd2;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (take) state_d = S_EXEC;
      S_EXEC: begin
        if (m_rd) state_d = S_WAIT;
        else if (!(ok_write && !last_step)) state_d = S_OUT;
      end
      S_WAIT: state_d = S_RESP;
      S_RESP: state_d = S_OUT;
      S_OUT:  if (!res_valid_q || !res_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q <= '0;
      step_q <= '0; cnt_q <= '0;
      hx_q <= '0; hy_q <= '0; sx_q <= '0; sy_q <= '0;
      bx_q <= '0; by_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && state_d == S_IDLE) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && !res_stall_i) begin
        res_valid_q <= 1'b0;
      end
      if (take) begin
        cmd_q <= cmd_i;
        step_q <= '0; bx_q <= hx_q; by_q <= hy_q;
      end
      if (state_q == S_EXEC) begin
        if (act == pbb_pkg::ACT_NEW) begin
          cnt_q <= '0; hx_q <= '0; hy_q <= '0; sx_q <= '0; sy_q <= '0;
        end
        if (ok_write) begin
          cnt_q <= cnt_q + Nw'(1);
          hx_q <= nx; hy_q <= ny;
          step_q <= step_q + 2'd1;
          if (act <= pbb_pkg::ACT_RMOVE) begin
            sx_q <= nx; sy_q <= ny;
          end
        end
      end
      if (m_wr && state_q == S_RESP) begin
        cnt_q <= cnt_q + Nw'(1);
        hx_q <= sx_q; hy_q <= sy_q;
      end
    end
  end

  always_comb begin
    work_d = '0;
    work_d.status = st;
    if (act == pbb_pkg::ACT_BBOX && st == pbb_pkg::ST_OK) begin
      work_d.box_low_x  = 32'(box[0]);
      work_d.box_low_y  = 32'(box[1]);
      work_d.box_high_x = 32'(box[2]);
      work_d.box_high_y = 32'(box[3]);
    end
  end

  always_comb begin
    res_d = work_q;
    res_d.current_x  = 32'(hx_q);
    res_d.current_y  = 32'(hy_q);
    res_d.node_total = 12'(cnt_q);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      work_q <= work_d;
    end else if (state_q == S_RESP && act == pbb_pkg::ACT_READ) begin
      work_q.read_kind <= r_kind;
      work_q.read_x    <= 32'($signed(r_x));
      work_q.read_y    <= 32'($signed(r_y));
    end
    if (state_q == S_OUT && state_d == S_IDLE) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Nw'(NODE_DEPTH)) else $error("node count beyond depth");
  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_wr |-> cnt_q < Nw'(NODE_DEPTH)) else $error("write into full memory");
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> cmd_stall_o) else $error("command taken while busy");
  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
`endif

endmodule

### sv/pbb_node_mem.sv
// Single-port node memory holding kind and absolute point of each node.
module pbb_node_mem #(
  parameter int Depth = 2048,
  parameter int Cw    = 32,
  parameter int Aw    = 11
) (
  input  logic              clk_i,
  input  logic              wr_i,
  input  logic              rd_i,
  input  logic [Aw-1:0]     addr_i,
  input  logic [2:0]        wkind_i,
  input  logic [Cw-1:0]     wx_i,
  input  logic [Cw-1:0]     wy_i,
  output logic [2:0]        rkind_o,
  output logic [Cw-1:0]     rx_o,
  output logic [Cw-1:0]     ry_o
);

  logic [2*Cw+2:0] mem [Depth];
  logic [2*Cw+2:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[addr_i] <= {wkind_i, wx_i, wy_i};
    end else if (rd_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rkind_o = rdata_q[2*Cw+2:2*Cw];
  assign rx_o    = rdata_q[2*Cw-1:Cw];
  assign ry_o    = rdata_q[Cw-1:0];

endmodule

### sv/pbb_box.sv
// Running full box and drawn box tracker.
module pbb_box #(
  parameter int Cw = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  logic                 pt_i,
  input  logic                 drawn_i,
  input  logic signed [Cw-1:0] x_i,
  input  logic signed [Cw-1:0] y_i,
  input  logic                 sel_drawn_i,
  output logic signed [Cw-1:0] box_o [4]
);

  logic signed [Cw-1:0] full_q [4];
  logic signed [Cw-1:0] drawn_q [4];
  logic signed [Cw-1:0] full_d [4];
  logic signed [Cw-1:0] drawn_d [4];
  logic started_q, only_moves_q;

  always_comb begin
    logic signed [Cw-1:0] b [4];
    if (started_q) begin
      b = full_q;
      drawn_d = drawn_q;
    end else begin
      b[0] = x_i; b[1] = y_i; b[2] = x_i; b[3] = y_i;
      drawn_d = b;
    end
    full_d = b;
    if (x_i < b[0]) full_d[0] = x_i;
    if (y_i < b[1]) full_d[1] = y_i;
    if (x_i > b[2]) full_d[2] = x_i;
    if (y_i > b[3]) full_d[3] = y_i;
    if (drawn_i) begin
      drawn_d = full_d;
    end else if (only_moves_q) begin
      if (x_i < drawn_d[0]) drawn_d[0] = x_i;
      if (y_i < drawn_d[1]) drawn_d[1] = y_i;
      if (x_i > drawn_d[2]) drawn_d[2] = x_i;
      if (y_i > drawn_d[3]) drawn_d[3] = y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q       <= '{default: '0};
      drawn_q      <= '{default: '0};
      started_q    <= 1'b0;
      only_moves_q <= 1'b1;
    end else if (clear_i) begin
      full_q       <= '{default: '0};
      drawn_q      <= '{default: '0};
      started_q    <= 1'b0;
      only_moves_q <= 1'b1;
    end else if (pt_i) begin
      full_q    <= full_d;
      drawn_q   <= drawn_d;
      started_q <= 1'b1;
      if (drawn_i) only_moves_q <= 1'b0;
    end
  end

  always_comb begin
    if (sel_drawn_i) begin
      box_o = drawn_q;
    end else begin
      box_o = full_q;
    end
  end

endmodule
